FILE: rtl/core/rrts_pkg.sv
package rrts_pkg;

  // job queue depth and derived widths
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ID_W      = 8;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned QUANTUM_W = 8;
  localparam int unsigned BUDGET_W  = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned JOB_W     = ID_W + BURST_W;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_RAN          = 3'd1,
    ST_IDLE         = 3'd2,
    ST_BUDGET_SPENT = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_QUANTUM     = 1'b0,
    CFG_TICK_BUDGET = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               kind;
    logic [ID_W-1:0]    job_id;
    logic [BURST_W-1:0] burst;
  } cmd_t;

endpackage

FILE: rtl/core/rrts_front.sv
module rrts_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  rrts_pkg::cmd_e              s_kind_i,
  input  logic [rrts_pkg::ID_W-1:0]   s_job_id_i,
  input  logic [rrts_pkg::BURST_W-1:0] s_burst_i,
  output rrts_pkg::cmd_t              cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_pop_i
);

  // two-entry command queue between intake and execution
  localparam int unsigned CQ_DEPTH = 2;

  rrts_pkg::cmd_t cq_q [CQ_DEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  rrts_pkg::cmd_t in_cmd;

  assign s_ready_o   = (cnt_q != 2'(CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cq_q[rd_ptr_q];

  assign push = s_valid_i && s_ready_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    in_cmd.kind   = s_kind_i;
    in_cmd.job_id = s_job_id_i;
    // payload of a tick carries nothing
    in_cmd.burst  = (s_kind_i == rrts_pkg::CMD_ADD) ? s_burst_i : '0;
    if (s_kind_i != rrts_pkg::CMD_ADD) begin
      in_cmd.job_id = '0;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cq_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

FILE: rtl/core/rrts_back.sv
module rrts_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrts_pkg::cmd_t               cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [rrts_pkg::CFG_W-1:0]   cfg_data_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output rrts_pkg::status_e            m_status_o,
  output logic [rrts_pkg::ID_W-1:0]    m_running_id_o,
  output logic                         m_job_done_o
);

  localparam int unsigned PW = rrts_pkg::PTR_W;
  localparam int unsigned CW = rrts_pkg::CNT_W;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
    ptr_next = (ptr == PW'(rrts_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  // job queue storage, {id, remaining burst}
  logic [rrts_pkg::JOB_W-1:0] mem_q [rrts_pkg::QUEUE_DEPTH];

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                              cur_valid_q, cur_valid_d;
  logic [rrts_pkg::JOB_W-1:0]        cur_job_q, cur_job_d;
  logic [rrts_pkg::QUANTUM_W-1:0]    slice_q, slice_d;
  logic [rrts_pkg::BUDGET_W-1:0]     ticks_q, ticks_d;
  logic [rrts_pkg::QUANTUM_W-1:0]    quantum_q;

  logic                              m_valid_q;
  rrts_pkg::status_e                 m_status_q;
  logic [rrts_pkg::ID_W-1:0]         m_id_q;
  logic                              m_done_q;

  logic                              out_free, fifo_full, emit;
  logic                              mem_we, pop_en, cur_upd;
  logic [rrts_pkg::JOB_W-1:0]        mem_wdata;
  rrts_pkg::status_e                 st;
  logic [rrts_pkg::ID_W-1:0]         rid;
  logic                              done;
  logic [rrts_pkg::ID_W-1:0]         cur_id;
  logic [rrts_pkg::BURST_W-1:0]      cur_rem, rem_dec;
  logic [rrts_pkg::QUANTUM_W-1:0]    slice_inc, q_eff;

  assign out_free  = !m_valid_q || m_ready_i;
  assign fifo_full = (cnt_q == CW'(rrts_pkg::QUEUE_DEPTH));
  assign cur_id    = cur_job_q[rrts_pkg::JOB_W-1:rrts_pkg::BURST_W];
  assign cur_rem   = cur_job_q[rrts_pkg::BURST_W-1:0];
  assign rem_dec   = (cur_rem == '0) ? '0 : cur_rem - rrts_pkg::BURST_W'(1);
  assign slice_inc = slice_q + rrts_pkg::QUANTUM_W'(1);
  assign q_eff     = (quantum_q == '0) ? rrts_pkg::QUANTUM_W'(1) : quantum_q;

  always_comb begin
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    st          = rrts_pkg::ST_ACCEPTED;
    rid         = '0;
    done        = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = {cmd_i.job_id, cmd_i.burst};
    pop_en      = 1'b0;
    cur_upd     = 1'b0;
    cur_job_d   = cur_job_q;
    cur_valid_d = cur_valid_q;
    slice_d     = slice_q;
    ticks_d     = ticks_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;

    if (cmd_valid_i && out_free) begin
      if (cmd_i.kind == rrts_pkg::CMD_ADD) begin
        cmd_pop_o = 1'b1;
        emit      = 1'b1;
        if (fifo_full) begin
          st = rrts_pkg::ST_OVERFLOW;
        end else begin
          mem_we = 1'b1;
          tail_d = ptr_next(tail_q);
          cnt_d  = cnt_q + CW'(1);
        end
      end else if (ticks_q == '0) begin
        cmd_pop_o = 1'b1;
        emit      = 1'b1;
        st        = rrts_pkg::ST_BUDGET_SPENT;
      end else if (!cur_valid_q && cnt_q != '0) begin
        // load head job into the current register, the tick stays queued and is retried
        pop_en      = 1'b1;
        head_d      = ptr_next(head_q);
        cnt_d       = cnt_q - CW'(1);
        cur_valid_d = 1'b1;
        slice_d     = '0;
      end else if (!cur_valid_q) begin
        cmd_pop_o = 1'b1;
        emit      = 1'b1;
        st        = rrts_pkg::ST_IDLE;
        ticks_d   = ticks_q - rrts_pkg::BUDGET_W'(1);
      end else begin
        cmd_pop_o = 1'b1;
        emit      = 1'b1;
        st        = rrts_pkg::ST_RAN;
        rid       = cur_id;
        ticks_d   = ticks_q - rrts_pkg::BUDGET_W'(1);
        cur_upd   = 1'b1;
        cur_job_d = {cur_id, rem_dec};
        if (rem_dec == '0) begin
          done        = 1'b1;
          cur_valid_d = 1'b0;
          slice_d     = '0;
        end else if (slice_inc >= q_eff) begin
          slice_d = '0;
          // requeue at the tail; if full the job just keeps running
          if (!fifo_full) begin
            mem_we      = 1'b1;
            mem_wdata   = {cur_id, rem_dec};
            tail_d      = ptr_next(tail_q);
            cnt_d       = cnt_q + CW'(1);
            cur_valid_d = 1'b0;
          end
        end else begin
          slice_d = slice_inc;
        end
      end
    end

    // a budget write reloads the remaining ticks
    if (cfg_we_i && cfg_idx_i == rrts_pkg::CFG_TICK_BUDGET) begin
      ticks_d = cfg_data_i[rrts_pkg::BUDGET_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      cur_valid_q <= 1'b0;
      slice_q     <= '0;
      ticks_q     <= '1;
      quantum_q   <= rrts_pkg::QUANTUM_W'(4);
      m_valid_q   <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      cur_valid_q <= cur_valid_d;
      slice_q     <= slice_d;
      ticks_q     <= ticks_d;
      if (cfg_we_i && cfg_idx_i == rrts_pkg::CFG_QUANTUM) begin
        quantum_q <= cfg_data_i[rrts_pkg::QUANTUM_W-1:0];
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= mem_wdata;
    end
    if (pop_en) begin
      cur_job_q <= mem_q[head_q];
    end else if (cur_upd) begin
      cur_job_q <= cur_job_d;
    end
    if (emit) begin
      m_status_q <= st;
      m_id_q     <= rid;
      m_done_q   <= done;
    end
  end

  assign m_valid_o      = m_valid_q;
  assign m_status_o     = m_status_q;
  assign m_running_id_o = m_id_q;
  assign m_job_done_o   = m_done_q;

endmodule

FILE: rtl/core/round_robin_time_slice_scheduler_top.sv
// channel   | dir | tdata (low bit up)               | tuser
// ----------+-----+----------------------------------+-------------------
// s_axis    | in  | job_id[7:0], burst[23:8]         | cmd[0]
// m_axis    | out | running_id[7:0], job_done[8], 0s | status[2:0]
// cfg       | in  | cfg_data_i: quantum or tick_budget by cfg_idx_i
//
// an add or a tick on a running job is handled directly in the back end; a tick that
// must load the head job first reads it through the single job queue port, then runs
// a two-entry command queue lets intake go on while the result register is stalled
// reset clears pointers, counts and the current job; queue entries hold no reset value
// m_axis_tready low holds the result register and, once the command queue fills,
// drops s_axis_tready
module round_robin_time_slice_scheduler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // job_id, burst
  input  logic [0:0]                 s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // running_id, job_done, zero fill
  output logic [2:0]                 m_axis_tuser,  // status
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rrts_pkg::CFG_W-1:0] cfg_data_i
);

  rrts_pkg::cmd_t            cmd;
  logic                      cmd_valid, cmd_pop;
  rrts_pkg::status_e         status;
  logic [rrts_pkg::ID_W-1:0] running_id;
  logic                      job_done;

  rrts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_kind_i    (rrts_pkg::cmd_e'(s_axis_tuser[0])),
    .s_job_id_i  (s_axis_tdata[7:0]),
    .s_burst_i   (s_axis_tdata[23:8]),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  rrts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_status_o     (status),
    .m_running_id_o (running_id),
    .m_job_done_o   (job_done)
  );

  assign m_axis_tdata = {7'd0, job_done, running_id};
  assign m_axis_tuser = status;

endmodule

FILE: rtl/core/rrts_checker.sv
module rrts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // only a ran result carries an id or a finish flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != rrts_pkg::ST_RAN |-> m_axis_tdata == 16'd0)
    else $error("payload set on a non-ran result");

  // status code within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == rrts_pkg::ST_ACCEPTED || m_axis_tuser == rrts_pkg::ST_RAN
      || m_axis_tuser == rrts_pkg::ST_IDLE || m_axis_tuser == rrts_pkg::ST_BUDGET_SPENT
      || m_axis_tuser == rrts_pkg::ST_OVERFLOW)
    else $error("undefined status");

  // zero fill above job_done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("tdata fill not zero");

endmodule

bind round_robin_time_slice_scheduler_top rrts_checker u_rrts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
